// ----- src/mrta_pkg.sv -----
// Shared types and constants for the aging mesh routing table.
// Word formats of the item and result channels, action codes, register indexes.
// No dependencies.
package mrta_pkg;

  localparam int unsigned NODE_W   = 16;
  localparam int unsigned HOPS_W   = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SWEEP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_NODE_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_TIMEOUT = 2'd1;

  localparam logic [NODE_W-1:0] RESET_OWN_NODE_ID = 16'd1;
  localparam logic [TIME_W-1:0] RESET_STALE_TIMEOUT = 32'd300000;
  localparam logic [HOPS_W-1:0] HOPS_MAX = 8'hFF;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [NODE_W-1:0]   node;
    logic [HOPS_W-1:0]   hops_in;
    logic [TIME_W-1:0]   now_ms;
  } mrta_in_t;

  typedef struct packed {
    logic               found;
    logic [NODE_W-1:0]  next_hop;
    logic [HOPS_W-1:0]  hop_distance;
    logic [COUNT_W-1:0] entry_count;
    logic [COUNT_W-1:0] removed_count;
  } mrta_out_t;

endpackage

// ----- src/mesh_route_table_aging.sv -----
// An item walks the entries up to the entry count at accept; an early match ends the walk,
// and own-id updates and unused actions skip the walk and go straight to the result.
// Throughput is set by the single read port of the entry memory: the walk
// reads one entry per cycle, and a new item is taken only once the last result is registered.
// Reset clears the entry count and handshake state and sets the config registers to
// their reset values; the entry memory is not cleared, data of entries past the count is never used.
module mesh_route_table_aging #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  mrta_pkg::mrta_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output mrta_pkg::mrta_out_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mrta_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mrta_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import mrta_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] next_hop;
    logic [HOPS_W-1:0] hops;
    logic [TIME_W-1:0] seen_time;
  } entry_t;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_e;

  state_e        state_q, state_d;
  mrta_in_t      req_q, req_d;
  mrta_out_t     res_q, res_d;
  mrta_out_t     out_q, out_d;
  logic          out_valid_q, out_valid_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] wr_q, wr_d;
  logic [CNT_W-1:0] removed_q, removed_d;
  logic          rvld_q, rvld_d;
  logic [IDX_W-1:0] ridx_q, ridx_d;
  logic [NODE_W-1:0] own_id_q;
  logic [TIME_W-1:0] timeout_q;

  // entry memory, one read and one write port
  entry_t        mem_q [TABLE_ENTRIES];
  entry_t        rdata_q;
  logic          we;
  logic [IDX_W-1:0] waddr;
  entry_t        wdata;

  logic          issue, hit, finish, stale;
  logic [HOPS_W-1:0] hops_new;
  logic [TIME_W-1:0] age;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q  <= RESET_OWN_NODE_ID;
      timeout_q <= RESET_STALE_TIMEOUT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_OWN_NODE_ID:   own_id_q  <= cfg_data_i[NODE_W-1:0];
        REG_STALE_TIMEOUT: timeout_q <= cfg_data_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[rd_q[IDX_W-1:0]];
  end

  assign hops_new = (req_q.hops_in == HOPS_MAX) ? HOPS_MAX : req_q.hops_in + HOPS_W'(1);
  assign age      = req_q.now_ms - rdata_q.seen_time;
  assign stale    = age > timeout_q;
  assign issue    = rd_q < cnt_q;
  assign hit      = rvld_q && (req_q.action != ACT_SWEEP) && (rdata_q.node == req_q.node);
  assign finish   = !rvld_q && !issue;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    removed_d   = removed_q;
    rvld_d      = 1'b0;
    ridx_d      = rd_q[IDX_W-1:0];
    we          = 1'b0;
    waddr       = wr_q[IDX_W-1:0];
    wdata       = rdata_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d     = in_data_i;
          res_d     = '0;
          rd_d      = '0;
          wr_d      = '0;
          removed_d = '0;
          if ((in_data_i.action == ACT_UPDATE && in_data_i.node != own_id_q) ||
              in_data_i.action == ACT_LOOKUP || in_data_i.action == ACT_SWEEP) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        rvld_d = issue;
        if (issue) begin
          rd_d = rd_q + CNT_W'(1);
        end
        // compaction: survivors move down to the write pointer, never above reads
        if (rvld_q && req_q.action == ACT_SWEEP) begin
          if (stale) begin
            removed_d = removed_q + CNT_W'(1);
          end else begin
            we    = 1'b1;
            waddr = wr_q[IDX_W-1:0];
            wdata = rdata_q;
            wr_d  = wr_q + CNT_W'(1);
          end
        end
        if (hit) begin
          rvld_d        = 1'b0;
          state_d       = ST_DONE;
          res_d.found   = 1'b1;
          if (req_q.action == ACT_UPDATE) begin
            we                 = 1'b1;
            waddr              = ridx_q;
            wdata.node         = req_q.node;
            wdata.next_hop     = req_q.node;
            wdata.hops         = hops_new;
            wdata.seen_time    = req_q.now_ms;
            res_d.next_hop     = req_q.node;
            res_d.hop_distance = hops_new;
          end else begin
            res_d.next_hop     = rdata_q.next_hop;
            res_d.hop_distance = rdata_q.hops;
          end
        end else if (finish) begin
          state_d = ST_DONE;
          if (req_q.action == ACT_SWEEP) begin
            cnt_d               = wr_q;
            res_d.removed_count = COUNT_W'(removed_q);
          end else if (req_q.action == ACT_UPDATE && cnt_q < CNT_FULL) begin
            // no match: append at the tail
            we                 = 1'b1;
            waddr              = cnt_q[IDX_W-1:0];
            wdata.node         = req_q.node;
            wdata.next_hop     = req_q.node;
            wdata.hops         = hops_new;
            wdata.seen_time    = req_q.now_ms;
            cnt_d              = cnt_q + CNT_W'(1);
            res_d.found        = 1'b1;
            res_d.next_hop     = req_q.node;
            res_d.hop_distance = hops_new;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d             = res_q;
          out_d.entry_count = COUNT_W'(cnt_q);
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      rvld_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      rvld_q      <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    res_q     <= res_d;
    out_q     <= out_d;
    rd_q      <= rd_d;
    wr_q      <= wr_d;
    removed_q <= removed_d;
    ridx_q    <= ridx_d;
  end

endmodule

// ----- src/mrta_checker.sv -----
// Port-level checks for the aging mesh routing table, bound to the top level.
// Depends on mrta_pkg and mesh_route_table_aging.
module mrta_checker #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input mrta_pkg::mrta_out_t out_data_o
);
  import mrta_pkg::*;

  // a word stalled on the result side holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed or dropped while stalled");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while previous one in work");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.entry_count <= COUNT_W'(TABLE_ENTRIES)) &&
                    (out_data_o.removed_count <= COUNT_W'(TABLE_ENTRIES)))
    else $error("entry or removed count beyond table size");

  a_sweep_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.removed_count != '0 |-> !out_data_o.found)
    else $error("sweep result reports a hit");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |->
      out_data_o.next_hop == '0 && out_data_o.hop_distance == '0)
    else $error("miss carries route data");

endmodule

bind mesh_route_table_aging mrta_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_mrta_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
